[sv/sef_pkg.sv]
// Shared constants, codes and types of the star erosion filter.
package sef_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_RADIUS = 31;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int RAD_CFG_W  = 5;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 12'd1280;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd960;
  localparam logic [RAD_CFG_W-1:0]  RST_RADIUS       = 5'd22;

  localparam logic [PIX_W-1:0] FULL_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] BACK_VALUE = 8'd0;

  // result queue depth, power of two (pointers wrap naturally)
  localparam int RES_FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             produce;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } res_meta_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_item_t;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[sv/sef_ifs.sv]
// Channel interfaces: pixel input, result output and configuration write.
interface sef_pix_if;
  import sef_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_pixel;
  logic             frame_start;
  modport source (output valid, in_pixel, frame_start, input ready);
  modport sink (input valid, in_pixel, frame_start, output ready);
endinterface

interface sef_res_if;
  import sef_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic [PIX_W-1:0] out_pixel;
  logic             last_of_frame;
  modport source (output valid, out_row, out_col, out_pixel, last_of_frame, input ready);
  modport sink (input valid, out_row, out_col, out_pixel, last_of_frame, output ready);
endinterface

interface sef_cfg_if;
  import sef_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/star_erosion_filter_top.sv]
// Star erosion filter top level: position tracking, configuration, credits, output.
// Takes one pixel per clock while input ready is high, in raster order, and returns one
// eroded value for each pixel at least radius away from every edge; the result for a
// center is formed from the pixel that completes its star (center row plus radius,
// center column plus radius) through the store stages, the ray test and the result queue.
// The rate is set by the column store, a memory with one read and one write port, of
// MAX_WIDTH words of 2*MAX_RADIUS+1 bits, that each pixel reads and writes back once; a
// write forward covers frames so narrow that consecutive pixels hit the same column.
// There is no clearing pass: store contents are unknown after reset, and only rows of the
// current frame are ever tested. Input ready drops only when eight results are queued or
// in flight while the output stalls. Write configuration only between frames or while idle.
module star_erosion_filter_top #(
  parameter int MAX_WIDTH  = sef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sef_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = sef_pkg::DEF_MAX_RADIUS
) (
  input logic       clk,
  input logic       rst,
  sef_cfg_if.sink   cfg,
  sef_pix_if.sink   pix,
  sef_res_if.source res
);
  import sef_pkg::*;

  localparam int S     = 2*MAX_RADIUS+1;
  localparam int SW    = $clog2(S);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W1    = $clog2(MAX_WIDTH+1);
  localparam int H1    = $clog2(MAX_HEIGHT+1);
  localparam int RDW   = $clog2(MAX_RADIUS+1);
  localparam int WC    = max2(CFG_DATA_W, W1);
  localparam int HC    = max2(CFG_DATA_W, H1);
  localparam int RC    = max2(RAD_CFG_W, RDW);
  localparam int PW    = max2(max2(RW, CW), RDW+1);
  localparam int CNT_W = $clog2(RES_FIFO_DEPTH+1);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [RAD_CFG_W-1:0]  radius;

  logic [RW-1:0]    row_count;
  logic [CW-1:0]    col_count;
  logic [SW-1:0]    row_slot;
  logic [CNT_W-1:0] cnt;

  logic [WC-1:0]  w_wide;
  logic [HC-1:0]  h_wide;
  logic [RC-1:0]  r_wide;
  logic [W1-1:0]  w_eff;
  logic [H1-1:0]  h_eff;
  logic [RDW-1:0] r_eff;
  logic [RDW:0]   r2;

  logic [RW-1:0]  row_in;
  logic [CW-1:0]  col_in;
  logic           row_wrap;
  logic [RW-1:0]  py;
  logic [CW-1:0]  px;
  logic [SW-1:0]  slot_cur;
  logic [W1-1:0]  col_inc;
  logic [H1-1:0]  row_inc;
  logic [CW-1:0]  col_count_next;
  logic [RW-1:0]  row_count_next;
  logic [SW-1:0]  row_slot_next;

  logic           accept;
  logic           produce0;
  logic           res_pop;
  res_meta_t      meta0;
  res_meta_t      meta2;
  logic           s2_v;
  logic [S-1:0][S-1:0] wnd;
  logic           fifo_push;
  res_item_t      ray_item;
  res_item_t      res_item;

  // register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      radius       <= RST_RADIUS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        REG_RADIUS:       radius       <= RAD_CFG_W'(cfg.data);
        default: ;
      endcase
    end
  end

  // zero sizes act as one, oversize values saturate
  always_comb begin
    w_wide = WC'(image_width);
    h_wide = HC'(image_height);
    r_wide = RC'(radius);
    if (w_wide == '0) begin
      w_wide = WC'(1);
    end else if (w_wide > WC'(MAX_WIDTH)) begin
      w_wide = WC'(MAX_WIDTH);
    end
    if (h_wide == '0) begin
      h_wide = HC'(1);
    end else if (h_wide > HC'(MAX_HEIGHT)) begin
      h_wide = HC'(MAX_HEIGHT);
    end
    if (r_wide > RC'(MAX_RADIUS)) begin
      r_wide = RC'(MAX_RADIUS);
    end
    w_eff = W1'(w_wide);
    h_eff = H1'(h_wide);
    r_eff = RDW'(r_wide);
    r2    = (RDW+1)'(r_eff) << 1;
  end

  // position of this beat and of the next
  always_comb begin
    row_in   = pix.frame_start ? '0 : row_count;
    col_in   = pix.frame_start ? '0 : col_count;
    row_wrap = (H1'(row_in) >= h_eff);
    py       = row_wrap ? '0 : row_in;
    px       = (W1'(col_in) >= w_eff) ? '0 : col_in;
    slot_cur = (pix.frame_start || row_wrap) ? '0 : row_slot;

    col_inc = W1'(px) + W1'(1);
    row_inc = H1'(py) + H1'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      if (row_inc >= h_eff) begin
        row_count_next = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = RW'(row_inc);
        row_slot_next  = (slot_cur == SW'(S-1)) ? '0 : slot_cur + SW'(1);
      end
    end else begin
      col_count_next = CW'(col_inc);
      row_count_next = py;
      row_slot_next  = slot_cur;
    end

    produce0      = (PW'(py) >= PW'(r2)) && (PW'(px) >= PW'(r2));
    meta0.produce = produce0;
    meta0.row     = POS_W'(PW'(py) - PW'(r_eff));
    meta0.col     = POS_W'(PW'(px) - PW'(r_eff));
    meta0.last    = (H1'(py) == h_eff - H1'(1)) && (W1'(px) == w_eff - W1'(1));
  end

  assign pix.ready = (cnt < CNT_W'(RES_FIFO_DEPTH));
  assign accept    = pix.valid && pix.ready;
  assign res_pop   = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      row_slot  <= row_slot_next;
    end
  end

  // credits for results in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if ((accept && produce0) && !res_pop) begin
      cnt <= cnt + CNT_W'(1);
    end else if (!(accept && produce0) && res_pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  sef_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .acc      (accept),
    .addr     (px),
    .slot     (slot_cur),
    .fg       (|pix.in_pixel),
    .meta_in  (meta0),
    .wnd      (wnd),
    .out_v    (s2_v),
    .meta_out (meta2)
  );

  sef_ray #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ray (
    .clk     (clk),
    .rst     (rst),
    .r       (r_eff),
    .wnd     (wnd),
    .in_v    (s2_v),
    .meta_in (meta2),
    .push    (fifo_push),
    .item    (ray_item)
  );

  sef_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .din       (ray_item),
    .pop_ready (res.ready),
    .valid     (res.valid),
    .dout      (res_item)
  );

  assign res.out_row       = res_item.row;
  assign res.out_col       = res_item.col;
  assign res.out_pixel     = res_item.pixel;
  assign res.last_of_frame = res_item.last;

  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && produce0) |-> ##3 fifo_push)
    else $error("interior pixel did not reach the result queue on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(accept && produce0) |-> ##3 !fifo_push)
    else $error("result queued without a matching interior pixel");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (cnt != '0))
    else $error("result queued without a credit");

  a_binary_out: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.out_pixel == BACK_VALUE || res.out_pixel == FULL_VALUE))
    else $error("eroded value is neither 0 nor 255");

endmodule

[sv/sef_store.sv]
// Column store with read-modify-write, forwarding, and the column window shift line.
module sef_store #(
  parameter int MAX_WIDTH  = sef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = sef_pkg::DEF_MAX_RADIUS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    acc,
  input  logic [$clog2(MAX_WIDTH)-1:0]            addr,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]       slot,
  input  logic                                    fg,
  input  sef_pkg::res_meta_t                      meta_in,
  output logic [2*MAX_RADIUS:0][2*MAX_RADIUS:0]   wnd,
  output logic                                    out_v,
  output sef_pkg::res_meta_t                      meta_out
);
  import sef_pkg::*;

  localparam int S  = 2*MAX_RADIUS+1;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(S);

  // one word per column, bit s holds the row whose index mod S is s
  logic [S-1:0]  mem [MAX_WIDTH];
  logic [S-1:0]  rd_data;
  logic [S-1:0]  base;
  logic [S-1:0]  merged;
  logic [S-1:0]  rot;

  logic          s1_v;
  logic [AW-1:0] s1_addr;
  logic [SW-1:0] s1_slot;
  logic          s1_fg;
  res_meta_t     s1_meta;

  logic          fwd_v;
  logic [AW-1:0] fwd_addr;
  logic [S-1:0]  fwd_data;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      mem[s1_addr] <= merged;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      fwd_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      s1_v  <= acc;
      fwd_v <= s1_v;
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr <= addr;
      s1_slot <= slot;
      s1_fg   <= fg;
      s1_meta <= meta_in;
    end
    fwd_addr <= s1_addr;
    fwd_data <= merged;
    if (s1_v) begin
      meta_out <= s1_meta;
      wnd      <= {wnd[S-2:0], rot};
    end
  end

  // the write landing on the same edge as this beat's read is not in rd_data
  always_comb begin
    base = (fwd_v && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
    for (int i = 0; i < S; i++) begin
      merged[i] = (SW'(i) == s1_slot) ? s1_fg : base[i];
    end
  end

  // reorder so that bit d is the row d lines above the current one
  always_comb begin
    logic [SW:0] idx;
    for (int d = 0; d < S; d++) begin
      idx = (SW+1)'(s1_slot) + (SW+1)'(S - d);
      if (idx >= (SW+1)'(S)) begin
        idx = idx - (SW+1)'(S);
      end
      rot[d] = merged[idx[SW-1:0]];
    end
  end

endmodule

[sv/sef_ray.sv]
// Eight-ray star test over the column window, per-column hits registered.
module sef_ray #(
  parameter int MAX_RADIUS = sef_pkg::DEF_MAX_RADIUS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]       r,
  input  logic [2*MAX_RADIUS:0][2*MAX_RADIUS:0] wnd,
  input  logic                                  in_v,
  input  sef_pkg::res_meta_t                    meta_in,
  output logic                                  push,
  output sef_pkg::res_item_t                    item
);
  import sef_pkg::*;

  localparam int S   = 2*MAX_RADIUS+1;
  localparam int RDW = $clog2(MAX_RADIUS+1);
  localparam int OW  = RDW+2;

  logic [OW-1:0]       r2;
  logic [S-1:0]        r_oh;
  logic [S-1:0]        le2;
  logic [2*S-2:0]      oh2;
  logic [S-1:0][S-1:0] mask;
  logic [S-1:0]        colhit;
  logic [S-1:0]        colhit_q;
  logic                s3_v;
  res_meta_t           meta3;

  assign r2 = OW'(r) << 1;

  // window index k is columns back from newest, d is rows back; center at (r, r)
  always_comb begin
    for (int k = 0; k < S; k++) begin
      r_oh[k] = (OW'(k) == OW'(r));
      le2[k]  = (OW'(k) <= r2);
    end
    for (int s = 0; s < 2*S-1; s++) begin
      oh2[s] = (OW'(s) == r2);
    end
    for (int k = 0; k < S; k++) begin
      for (int d = 0; d < S; d++) begin
        mask[k][d] = ((r_oh[k] && le2[d]) || (r_oh[d] && le2[k]) ||
                      ((k == d) && le2[k]) || oh2[k+d]) && !(r_oh[k] && r_oh[d]);
      end
      colhit[k] = |(mask[k] & ~wnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    colhit_q <= colhit;
    if (in_v) begin
      meta3 <= meta_in;
    end
  end

  assign push       = s3_v && meta3.produce;
  assign item.row   = meta3.row;
  assign item.col   = meta3.col;
  assign item.last  = meta3.last;
  assign item.pixel = (|colhit_q) ? BACK_VALUE : FULL_VALUE;

endmodule

[sv/sef_fifo.sv]
// Result queue between the ray test and the output channel.
module sef_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sef_pkg::res_item_t din,
  input  logic               pop_ready,
  output logic               valid,
  output sef_pkg::res_item_t dout
);
  import sef_pkg::*;

  localparam int PW = $clog2(RES_FIFO_DEPTH);

  res_item_t     q_mem [RES_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          pop;

  assign valid = (count != '0);
  assign pop   = valid && pop_ready;
  assign dout  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule
